### rtl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and the symbol lookup for the line-wrapped base64
// encoder.
// ----------------------------------------------------------------------------
package b64_pkg;

   // Column counter width (line widths up to 124 plus one group of four)
   localparam int COL_W = 7;

   // Depth of the group queue between front and back
   localparam int GROUP_FIFO_DEPTH = 2;
   localparam int GROUP_PTR_W      = $clog2(GROUP_FIFO_DEPTH);
   localparam int GROUP_CNT_W      = $clog2(GROUP_FIFO_DEPTH + 1);

   // Characters that are not alphabet symbols
   localparam logic [7:0] CHAR_PAD = 8'h3D;   // '='
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;

   // Bytes held before a group is complete
   localparam logic [1:0] HELD_NONE = 2'd0;
   localparam logic [1:0] HELD_ONE  = 2'd1;
   localparam logic [1:0] HELD_TWO  = 2'd2;

   // Output character slot within one group
   typedef enum logic [2:0] {
      SLOT_SYM0 = 3'd0,
      SLOT_SYM1 = 3'd1,
      SLOT_SYM2 = 3'd2,
      SLOT_SYM3 = 3'd3,
      SLOT_CR   = 3'd4,
      SLOT_LF   = 3'd5
   } b64_slot_type;

   // One complete group, as handed from front to back
   typedef struct packed {
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [7:0] byte_c;
      logic [1:0] nbytes;      // 1..3 real bytes in the group
      logic       line_break;  // append CR LF after the four symbols
      logic       last;        // group closes the message
   } b64_group_type;

   // Map a 6-bit value to its character in the standard alphabet
   function automatic logic [7:0] b64_symbol(input logic [5:0] v);
      logic [7:0] ch;
      if (v < 6'd26) begin
         ch = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         ch = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         ch = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         ch = 8'h2B;
      end else begin
         ch = 8'h2F;
      end
      return ch;
   endfunction

endpackage

### rtl/b64_req_if.sv
// ----------------------------------------------------------------------------
// b64_req_if
// Byte input channel: one raw byte per transaction, with a final marker.
// ----------------------------------------------------------------------------
interface b64_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

### rtl/b64_rsp_if.sv
// ----------------------------------------------------------------------------
// b64_rsp_if
// Character output channel: one encoded character per transaction.
// ----------------------------------------------------------------------------
interface b64_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_end;
   logic       message_end;

   modport source (output valid, output out_char, output run_end, output message_end,
                   input ready);
   modport sink   (input valid, input out_char, input run_end, input message_end,
                   output ready);
endinterface

### rtl/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front
// Gathers bytes into groups of three, tracks the line column and pushes each
// complete group, with its padding and line-break decision, to the queue.
// ----------------------------------------------------------------------------
module b64_front import b64_pkg::*; #(
   parameter int LINE_CHARS = 76
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [7:0]    in_byte,
   input  logic          in_final,
   input  logic          grp_full,
   output logic          grp_push,
   output b64_group_type grp_data
);

   logic [7:0]       held_first_ff, held_first_in;
   logic [7:0]       held_second_ff, held_second_in;
   logic [1:0]       held_count_ff, held_count_in;
   logic [COL_W-1:0] column_ff, column_in;

   logic             accept;
   logic             emit;
   logic [COL_W:0]   col_sum;
   logic             brk;

   assign in_ready = !grp_full;
   assign accept   = in_valid && in_ready;
   assign emit     = in_final || (held_count_ff == HELD_TWO);

   // Column after this group and the wrap decision
   assign col_sum = {1'b0, column_ff} + (COL_W + 1)'(4);
   assign brk     = col_sum >= (COL_W + 1)'(LINE_CHARS);

   // Assemble the group from held bytes and the incoming one
   always_comb begin
      grp_data            = '0;
      grp_data.line_break = brk;
      grp_data.last       = in_final;
      case (held_count_ff)
         HELD_NONE: begin
            grp_data.byte_a = in_byte;
            grp_data.nbytes = 2'd1;
         end
         HELD_ONE: begin
            grp_data.byte_a = held_first_ff;
            grp_data.byte_b = in_byte;
            grp_data.nbytes = 2'd2;
         end
         default: begin
            grp_data.byte_a = held_first_ff;
            grp_data.byte_b = held_second_ff;
            grp_data.byte_c = in_byte;
            grp_data.nbytes = 2'd3;
         end
      endcase
   end

   assign grp_push = accept && emit;

   // Next state of the holding registers and column count
   always_comb begin
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      held_count_in  = held_count_ff;
      column_in      = column_ff;
      if (accept) begin
         if (!emit) begin
            if (held_count_ff == HELD_NONE) begin
               held_first_in = in_byte;
            end else begin
               held_second_in = in_byte;
            end
            held_count_in = held_count_ff + 2'd1;
         end else begin
            held_count_in = HELD_NONE;
            if (in_final || brk) begin
               column_in = '0;
            end else begin
               column_in = col_sum[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= HELD_NONE;
         column_ff     <= '0;
      end else begin
         held_count_ff <= held_count_in;
         column_ff     <= column_in;
      end
   end

   // Held bytes are payload only
   always_ff @(posedge clock) begin
      held_first_ff  <= held_first_in;
      held_second_ff <= held_second_in;
   end

endmodule

### rtl/b64_group_fifo.sv
// ----------------------------------------------------------------------------
// b64_group_fifo
// Short queue of complete groups between the front and the back.
// ----------------------------------------------------------------------------
module b64_group_fifo import b64_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  b64_group_type push_data,
   input  logic          pop,
   output logic          full,
   output logic          empty,
   output b64_group_type head
);

   b64_group_type          mem [GROUP_FIFO_DEPTH];
   logic [GROUP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [GROUP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [GROUP_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = count_ff == GROUP_CNT_W'(GROUP_FIFO_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back
// Walks the head group one character per cycle unless stalled: four symbols
// or pads, then CR LF when the line wraps. Drives a registered output stage.
// ----------------------------------------------------------------------------
module b64_back import b64_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          grp_empty,
   input  b64_group_type grp_head,
   output logic          grp_pop,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [7:0]    out_char,
   output logic          out_run_end,
   output logic          out_msg_end
);

   b64_slot_type slot_ff, slot_in;
   logic         valid_ff, valid_in;
   logic [7:0]   char_ff, char_in;
   logic         run_end_ff, run_end_in;
   logic         msg_end_ff, msg_end_in;

   logic         out_free;
   logic         issue;
   logic         slot_last;
   logic [7:0]   slot_char;

   assign out_free = !valid_ff || out_ready;
   assign issue    = !grp_empty && out_free;

   // Character for the current slot
   always_comb begin
      slot_last = 1'b0;
      case (slot_ff)
         SLOT_SYM0: slot_char = b64_symbol(grp_head.byte_a[7:2]);
         SLOT_SYM1: slot_char = b64_symbol({grp_head.byte_a[1:0], grp_head.byte_b[7:4]});
         SLOT_SYM2: begin
            slot_char = (grp_head.nbytes >= 2'd2)
                      ? b64_symbol({grp_head.byte_b[3:0], grp_head.byte_c[7:6]})
                      : CHAR_PAD;
         end
         SLOT_SYM3: begin
            slot_char = (grp_head.nbytes == 2'd3) ? b64_symbol(grp_head.byte_c[5:0])
                                                  : CHAR_PAD;
            slot_last = !grp_head.line_break;
         end
         SLOT_CR:   slot_char = CHAR_CR;
         SLOT_LF: begin
            slot_char = CHAR_LF;
            slot_last = 1'b1;
         end
         default:   slot_char = CHAR_PAD;
      endcase
   end

   assign grp_pop = issue && slot_last;

   // Slot sequencing
   always_comb begin
      slot_in = slot_ff;
      if (issue) begin
         case (slot_ff)
            SLOT_SYM0: slot_in = SLOT_SYM1;
            SLOT_SYM1: slot_in = SLOT_SYM2;
            SLOT_SYM2: slot_in = SLOT_SYM3;
            SLOT_SYM3: slot_in = slot_last ? SLOT_SYM0 : SLOT_CR;
            SLOT_CR:   slot_in = SLOT_LF;
            default:   slot_in = SLOT_SYM0;
         endcase
      end
   end

   // Output register
   always_comb begin
      valid_in   = valid_ff;
      char_in    = char_ff;
      run_end_in = run_end_ff;
      msg_end_in = msg_end_ff;
      if (issue) begin
         valid_in   = 1'b1;
         char_in    = slot_char;
         run_end_in = slot_last;
         msg_end_in = slot_last && grp_head.last;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= SLOT_SYM0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff    <= char_in;
      run_end_ff <= run_end_in;
      msg_end_ff <= msg_end_in;
   end

   assign out_valid   = valid_ff;
   assign out_char    = char_ff;
   assign out_run_end = run_end_ff;
   assign out_msg_end = msg_end_ff;

endmodule

### rtl/base64_line_wrapped_encoder_unit.sv
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder_unit
// Streaming base64 encoder with CR LF line wrapping.
// ----------------------------------------------------------------------------
// Takes one byte per transaction and returns base64 characters one per
// transaction. Every third byte, or a byte marked final, closes a group that
// becomes four characters ('=' pads a short final group), followed by CR LF
// whenever the line reaches LINE_CHARS characters; the column restarts at zero
// after a final byte. Bytes are accepted one per cycle while the two-entry
// group queue has room; the output side emits one character per cycle unless
// stalled, so the single-character output port sets the sustained rate inside
// a message, and a short final group of one or two bytes still yields four or
// six characters. The first character of a group passes through the group
// queue and then the output register after its closing byte is accepted.
// run_end marks the last character caused by a byte, message_end the last
// character of the message.
module base64_line_wrapped_encoder_unit import b64_pkg::*; #(
   parameter int LINE_CHARS = 76
) (
   input  logic       clock,
   input  logic       reset,
   b64_req_if.sink    req_if,
   b64_rsp_if.source  rsp_if
);

   logic          grp_full;
   logic          grp_empty;
   logic          grp_push;
   logic          grp_pop;
   b64_group_type grp_push_data;
   b64_group_type grp_head;

   // Front: byte gathering and line tracking
   b64_front #(
      .LINE_CHARS (LINE_CHARS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_ready (req_if.ready),
      .in_byte  (req_if.data_byte),
      .in_final (req_if.final_byte),
      .grp_full (grp_full),
      .grp_push (grp_push),
      .grp_data (grp_push_data)
   );

   // Group queue
   b64_group_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_data (grp_push_data),
      .pop       (grp_pop),
      .full      (grp_full),
      .empty     (grp_empty),
      .head      (grp_head)
   );

   // Back: character emission
   b64_back u_back (
      .clock       (clock),
      .reset       (reset),
      .grp_empty   (grp_empty),
      .grp_head    (grp_head),
      .grp_pop     (grp_pop),
      .out_valid   (rsp_if.valid),
      .out_ready   (rsp_if.ready),
      .out_char    (rsp_if.out_char),
      .out_run_end (rsp_if.run_end),
      .out_msg_end (rsp_if.message_end)
   );

endmodule

### rtl/b64_checker.sv
// ----------------------------------------------------------------------------
// b64_checker
// Port-level checks for the base64 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64_checker import b64_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_run_end,
   input logic       rsp_message_end
);

   // A stalled character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char))
      else $error("b64: stalled output changed");

   // Output stage is empty right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("b64: output valid after reset");

   // Message end only on the last character of a run
   a_msg_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_run_end)
      else $error("b64: message_end without run_end");

   // CR is never last in a run, LF always is
   a_cr_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char != CHAR_CR || !rsp_run_end) &&
                    (rsp_out_char != CHAR_LF || rsp_run_end))
      else $error("b64: line break misplaced in run");

endmodule

bind base64_line_wrapped_encoder_unit b64_checker u_b64_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_out_char    (rsp_if.out_char),
   .rsp_run_end     (rsp_if.run_end),
   .rsp_message_end (rsp_if.message_end)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line-wrapped base64 encoder. Byte transactions
// go in on the request channel while a local encoder model builds the
// character stream that must come back. Every returned character is checked
// against the oldest predicted one, including its run_end and message_end
// flags. Both channels stall at random, apart from one long steady stretch.
// ----------------------------------------------------------------------------
module testbench;
   import b64_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int LINE_CHARS   = 76;
   localparam int ITEM_TARGET  = 470;
   localparam int IDLE_PCT     = 30;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   // Standard alphabet, first symbol in the top byte
   localparam logic [511:0] B64_SYMBOLS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct {
      logic [7:0] out_char;
      logic       run_end;
      logic       message_end;
   } encoded_char_type;

   logic clock = 1'b0;
   logic reset;
   logic steady_flow = 1'b0;
   int   fail_count = 0;
   int   items_sent = 0;
   int   cycle_count = 0;

   // Encoder state tracked by the local model
   logic [7:0]       held_a;
   logic [7:0]       held_b;
   logic [1:0]       held_count;
   logic [COL_W-1:0] line_col;

   encoded_char_type encoded_text_q [$];

   b64_req_if req_ch ();
   b64_rsp_if rsp_ch ();

   base64_line_wrapped_encoder_unit #(
      .LINE_CHARS (LINE_CHARS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   function automatic logic [7:0] symbol_of(input logic [5:0] v);
      return B64_SYMBOLS[511 - 8 * v -: 8];
   endfunction

   // Advance the encoder model by one byte and queue the characters it yields
   function automatic void encode_byte(input logic [7:0] data, input logic last);
      logic [7:0]       a;
      logic [7:0]       b;
      logic [7:0]       c;
      logic [COL_W-1:0] col;
      logic [7:0]       text [$];

      // Byte only parks until its group closes
      if (!last && held_count < HELD_TWO) begin
         if (held_count == HELD_NONE) begin
            held_a = data;
         end else begin
            held_b = data;
         end
         held_count = held_count + 2'd1;
         return;
      end

      case (held_count)
         HELD_NONE: begin
            a = data;   b = 8'h00;  c = 8'h00;
         end
         HELD_ONE: begin
            a = held_a; b = data;   c = 8'h00;
         end
         default: begin
            a = held_a; b = held_b; c = data;
         end
      endcase

      text.push_back(symbol_of(a[7:2]));
      text.push_back(symbol_of({a[1:0], b[7:4]}));
      text.push_back(held_count != HELD_NONE ? symbol_of({b[3:0], c[7:6]}) : CHAR_PAD);
      text.push_back(held_count == HELD_TWO ? symbol_of(c[5:0]) : CHAR_PAD);

      // Line wrap, also right after the last group of a message
      col = line_col + COL_W'(4);
      if (col >= LINE_CHARS) begin
         text.push_back(CHAR_CR);
         text.push_back(CHAR_LF);
         col = '0;
      end
      line_col   = last ? '0 : col;
      held_count = HELD_NONE;
      if (last) begin
         held_a = 8'h00;
         held_b = 8'h00;
      end

      foreach (text[i]) begin
         encoded_text_q.push_back('{out_char: text[i],
                                    run_end: (i == text.size() - 1),
                                    message_end: last && (i == text.size() - 1)});
      end
   endfunction

   // Result side: random back-pressure and compare against the model
   always @(posedge clock) begin
      encoded_char_type want;
      rsp_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (encoded_text_q.size() == 0) begin
            $error("unexpected character 0x%02h", rsp_ch.out_char);
            fail_count++;
         end else begin
            want = encoded_text_q.pop_front();
            if (rsp_ch.out_char !== want.out_char) begin
               $error("out_char: expected 0x%02h, got 0x%02h",
                      want.out_char, rsp_ch.out_char);
               fail_count++;
            end
            if (rsp_ch.run_end !== want.run_end) begin
               $error("run_end: expected %0b, got %0b", want.run_end, rsp_ch.run_end);
               fail_count++;
            end
            if (rsp_ch.message_end !== want.message_end) begin
               $error("message_end: expected %0b, got %0b",
                      want.message_end, rsp_ch.message_end);
               fail_count++;
            end
         end
      end
   end

   // One byte transaction, with an optional idle gap in front of it
   task automatic send_byte(input logic [7:0] data, input logic last);
      if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.data_byte  <= data;
      req_ch.final_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      encode_byte(data, last);
      items_sent++;
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   // Byte extremes, padded short groups and back-to-back messages
   task automatic test_short_groups();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      // full group, then a final pair
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h3C, 1'b1);
   endtask

   // Long messages without stalls: wrap at message end, mid-message, twice
   task automatic test_line_breaks();
      steady_flow = 1'b1;
      send_message(57);
      send_message(61);
      send_message(114);
      steady_flow = 1'b0;
   endtask

   // Mostly short messages, some long enough to wrap
   task automatic test_random_messages();
      int len;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 80) begin
            len = $urandom_range(1, 12);
         end else begin
            len = $urandom_range(13, 100);
         end
         if (len > ITEM_TARGET - items_sent) begin
            len = ITEM_TARGET - items_sent;
         end
         send_message(len);
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.data_byte  <= 8'h00;
      req_ch.final_byte <= 1'b0;
      held_a     = 8'h00;
      held_b     = 8'h00;
      held_count = HELD_NONE;
      line_col   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_groups();
      test_line_breaks();
      test_random_messages();

      // drain
      req_ch.valid <= 1'b0;
      while (encoded_text_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
